>>> design/z80alu_pkg.sv
// ============================================================================
// z80alu_pkg
// Shared types, operation codes and flag helpers for the Z80 8-bit ALU.
// ============================================================================
package z80alu_pkg;

    // Operation codes carried in req_type
    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_ADC = 5'd1;
    localparam logic [4:0] OP_SUB = 5'd2;
    localparam logic [4:0] OP_SBC = 5'd3;
    localparam logic [4:0] OP_AND = 5'd4;
    localparam logic [4:0] OP_XOR = 5'd5;
    localparam logic [4:0] OP_OR  = 5'd6;
    localparam logic [4:0] OP_CP  = 5'd7;
    localparam logic [4:0] OP_INC = 5'd8;
    localparam logic [4:0] OP_DEC = 5'd9;
    localparam logic [4:0] OP_NEG = 5'd10;
    localparam logic [4:0] OP_DAA = 5'd11;
    localparam logic [4:0] OP_CPL = 5'd12;
    localparam logic [4:0] OP_SCF = 5'd13;
    localparam logic [4:0] OP_CCF = 5'd14;
    localparam logic [4:0] OP_RLC = 5'd15;
    localparam logic [4:0] OP_RRC = 5'd16;
    localparam logic [4:0] OP_RL  = 5'd17;
    localparam logic [4:0] OP_RR  = 5'd18;
    localparam logic [4:0] OP_SLA = 5'd19;
    localparam logic [4:0] OP_SRA = 5'd20;
    localparam logic [4:0] OP_SLL = 5'd21;
    localparam logic [4:0] OP_SRL = 5'd22;
    localparam logic [4:0] OP_BIT = 5'd23;
    localparam logic [4:0] OP_SET = 5'd24;
    localparam logic [4:0] OP_RES = 5'd25;

    // Flag bit positions: S Z F5 H F3 PV N C
    localparam int FLAG_S  = 7;
    localparam int FLAG_Z  = 6;
    localparam int FLAG_5  = 5;
    localparam int FLAG_H  = 4;
    localparam int FLAG_3  = 3;
    localparam int FLAG_PV = 2;
    localparam int FLAG_N  = 1;
    localparam int FLAG_C  = 0;

    // Decimal adjust thresholds
    localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;
    localparam logic [7:0] SIGN_MASK      = 8'h80;

    typedef struct packed {
        logic [4:0] req_type;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [7:0] flags_in;
        logic [2:0] bit_index;
    } alu_req_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] flags_out;
        logic       write_back;
    } alu_rsp_t;

    // S, Z, F5, F3 taken from a result byte; other bits zero
    function automatic logic [7:0] sz53(input logic [7:0] r);
        logic [7:0] f;
        f          = 8'h00;
        f[FLAG_S]  = r[7];
        f[FLAG_Z]  = (r == 8'h00);
        f[FLAG_5]  = r[5];
        f[FLAG_3]  = r[3];
        return f;
    endfunction

    // Even parity: 1 when the byte has an even count of ones
    function automatic logic even_parity(input logic [7:0] r);
        return ~(^r);
    endfunction

endpackage

>>> design/z80alu_if.sv
// ============================================================================
// z80alu_if
// Valid/ready channels for ALU requests and ALU results.
// ============================================================================
interface z80alu_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] req_type;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [7:0] flags_in;
    logic [2:0] bit_index;

    modport source (output valid, output req_type, output operand_a,
                    output operand_b, output flags_in, output bit_index,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a,
                    input operand_b, input flags_in, input bit_index,
                    output ready);
endinterface

interface z80alu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic [7:0] flags_out;
    logic       write_back;

    modport source (output valid, output result, output flags_out,
                    output write_back, input ready);
    modport sink   (input valid, input result, input flags_out,
                    input write_back, output ready);
endinterface

>>> design/z80alu_calc.sv
// ============================================================================
// z80alu_calc
// Combinational datapath: result byte, flag byte and write-back strobe.
// ============================================================================
module z80alu_calc (
    input  z80alu_pkg::alu_req_t req,
    output z80alu_pkg::alu_rsp_t rsp
);
    import z80alu_pkg::*;

    logic [4:0] op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] fi;
    logic       cin;
    logic       ci;
    logic [7:0] mask;

    logic [8:0] add9;
    logic [4:0] addh;
    logic [7:0] sa;
    logic [7:0] sb;
    logic [8:0] sub9;
    logic [4:0] subh;
    logic [7:0] add_f;
    logic [7:0] sub_f;

    logic       daa_lo;
    logic       daa_hi;
    logic [7:0] daa_corr;
    logic [7:0] daa_r;
    logic       daa_h;

    logic [7:0] rot_r;
    logic       rot_c;
    logic [7:0] bit_t;

    assign op   = req.req_type;
    assign a    = req.operand_a;
    assign b    = req.operand_b;
    assign fi   = req.flags_in;
    assign cin  = fi[FLAG_C];
    assign ci   = ((op == OP_ADC) || (op == OP_SBC)) ? cin : 1'b0;
    assign mask = 8'h01 << req.bit_index;

    // Adder path
    assign add9 = {1'b0, a} + {1'b0, b} + {8'h00, ci};
    assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, ci};

    always_comb
    begin
        add_f          = sz53(add9[7:0]);
        add_f[FLAG_H]  = addh[4];
        add_f[FLAG_PV] = (~(a[7] ^ b[7])) & (a[7] ^ add9[7]);
        add_f[FLAG_C]  = add9[8];
    end

    // Subtractor path; NEG is 0 - a
    assign sa   = (op == OP_NEG) ? 8'h00 : a;
    assign sb   = (op == OP_NEG) ? a : b;
    assign sub9 = {1'b0, sa} - {1'b0, sb} - {8'h00, ci};
    assign subh = {1'b0, sa[3:0]} - {1'b0, sb[3:0]} - {4'h0, ci};

    always_comb
    begin
        sub_f          = sz53(sub9[7:0]);
        sub_f[FLAG_N]  = 1'b1;
        sub_f[FLAG_H]  = subh[4];
        sub_f[FLAG_PV] = (sa[7] ^ sb[7]) & (sa[7] ^ sub9[7]);
        sub_f[FLAG_C]  = sub9[8];
    end

    // Decimal adjust
    assign daa_lo   = fi[FLAG_H] || (a[3:0] > DAA_LOW_LIMIT);
    assign daa_hi   = cin || (a > DAA_HIGH_LIMIT);
    assign daa_corr = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
    assign daa_r    = fi[FLAG_N] ? (a - daa_corr) : (a + daa_corr);
    assign daa_h    = fi[FLAG_N] ? (fi[FLAG_H] && (a[3:0] < 4'd6))
                                 : (a[3:0] > DAA_LOW_LIMIT);

    // Rotates and shifts
    always_comb
    begin
        rot_c = a[0];
        rot_r = {1'b0, a[7:1]};
        unique case (op)
            OP_RLC:  begin rot_c = a[7]; rot_r = {a[6:0], a[7]};     end
            OP_RRC:  begin rot_c = a[0]; rot_r = {a[0], a[7:1]};     end
            OP_RL:   begin rot_c = a[7]; rot_r = {a[6:0], cin};      end
            OP_RR:   begin rot_c = a[0]; rot_r = {cin, a[7:1]};      end
            OP_SLA:  begin rot_c = a[7]; rot_r = {a[6:0], 1'b0};     end
            OP_SRA:  begin rot_c = a[0]; rot_r = {a[7], a[7:1]};     end
            OP_SLL:  begin rot_c = a[7]; rot_r = {a[6:0], 1'b1};     end
            default: begin rot_c = a[0]; rot_r = {1'b0, a[7:1]};     end
        endcase
    end

    assign bit_t = a & mask;

    // Result select
    always_comb
    begin
        rsp.result     = a;
        rsp.flags_out  = fi;
        rsp.write_back = 1'b1;
        unique case (op)
            OP_ADD, OP_ADC:
            begin
                rsp.result    = add9[7:0];
                rsp.flags_out = add_f;
            end
            OP_SUB, OP_SBC, OP_NEG:
            begin
                rsp.result    = sub9[7:0];
                rsp.flags_out = sub_f;
            end
            OP_CP:
            begin
                rsp.result            = sub9[7:0];
                rsp.flags_out         = sub_f;
                rsp.flags_out[FLAG_5] = b[5];
                rsp.flags_out[FLAG_3] = b[3];
                rsp.write_back        = 1'b0;
            end
            OP_AND:
            begin
                rsp.result                = a & b;
                rsp.flags_out             = sz53(a & b);
                rsp.flags_out[FLAG_H]     = 1'b1;
                rsp.flags_out[FLAG_PV]    = even_parity(a & b);
            end
            OP_XOR:
            begin
                rsp.result             = a ^ b;
                rsp.flags_out          = sz53(a ^ b);
                rsp.flags_out[FLAG_PV] = even_parity(a ^ b);
            end
            OP_OR:
            begin
                rsp.result             = a | b;
                rsp.flags_out          = sz53(a | b);
                rsp.flags_out[FLAG_PV] = even_parity(a | b);
            end
            OP_INC:
            begin
                rsp.result             = a + 8'h01;
                rsp.flags_out          = sz53(a + 8'h01);
                rsp.flags_out[FLAG_C]  = cin;
                rsp.flags_out[FLAG_H]  = (a[3:0] == 4'hF);
                rsp.flags_out[FLAG_PV] = (a == (SIGN_MASK - 8'h01));
            end
            OP_DEC:
            begin
                rsp.result             = a - 8'h01;
                rsp.flags_out          = sz53(a - 8'h01);
                rsp.flags_out[FLAG_C]  = cin;
                rsp.flags_out[FLAG_N]  = 1'b1;
                rsp.flags_out[FLAG_H]  = (a[3:0] == 4'h0);
                rsp.flags_out[FLAG_PV] = (a == SIGN_MASK);
            end
            OP_DAA:
            begin
                rsp.result             = daa_r;
                rsp.flags_out          = sz53(daa_r);
                rsp.flags_out[FLAG_PV] = even_parity(daa_r);
                rsp.flags_out[FLAG_H]  = daa_h;
                rsp.flags_out[FLAG_N]  = fi[FLAG_N];
                rsp.flags_out[FLAG_C]  = daa_hi;
            end
            OP_CPL:
            begin
                rsp.result            = ~a;
                rsp.flags_out[FLAG_5] = ~a[5];
                rsp.flags_out[FLAG_3] = ~a[3];
                rsp.flags_out[FLAG_H] = 1'b1;
                rsp.flags_out[FLAG_N] = 1'b1;
            end
            OP_SCF, OP_CCF:
            begin
                rsp.flags_out[FLAG_5] = a[5];
                rsp.flags_out[FLAG_3] = a[3];
                rsp.flags_out[FLAG_N] = 1'b0;
                rsp.flags_out[FLAG_H] = (op == OP_CCF) ? cin : 1'b0;
                rsp.flags_out[FLAG_C] = (op == OP_CCF) ? ~cin : 1'b1;
                rsp.write_back        = 1'b0;
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL:
            begin
                rsp.result             = rot_r;
                rsp.flags_out          = sz53(rot_r);
                rsp.flags_out[FLAG_PV] = even_parity(rot_r);
                rsp.flags_out[FLAG_C]  = rot_c;
            end
            OP_BIT:
            begin
                rsp.flags_out          = 8'h00;
                rsp.flags_out[FLAG_S]  = bit_t[7];
                rsp.flags_out[FLAG_5]  = bit_t[5];
                rsp.flags_out[FLAG_3]  = bit_t[3];
                rsp.flags_out[FLAG_Z]  = (bit_t == 8'h00);
                rsp.flags_out[FLAG_PV] = (bit_t == 8'h00);
                rsp.flags_out[FLAG_H]  = 1'b1;
                rsp.flags_out[FLAG_C]  = cin;
                rsp.write_back         = 1'b0;
            end
            OP_SET:
            begin
                rsp.result = a | mask;
            end
            OP_RES:
            begin
                rsp.result = a & ~mask;
            end
            default:
            begin
                rsp.write_back = 1'b0;
            end
        endcase
    end

endmodule

>>> design/z80_alu_with_flags_core.sv
// ============================================================================
// z80_alu_with_flags_core
// Z80 8-bit ALU with full flag generation behind valid/ready channels.
// ============================================================================
// Usage:
//   req : one transaction per ALU operation (req_type, operand_a, operand_b,
//         flags_in, bit_index). Accepted when req.valid and req.ready are high.
//   rsp : one transaction per request, in order (result, flags_out,
//         write_back). Taken when rsp.valid and rsp.ready are high.
//   Path: an accepted request is held in the request register, passes through
//   the ALU datapath into the result register and shows on rsp from there.
//   Throughput: one transaction per cycle while rsp.ready is high, set by the
//   single pass through the ALU datapath between request and result registers.
//   Reset: rst_n clears both valid bits asynchronously; the block is empty
//   and ready for a request once reset is released.
//   Stall: while rsp.ready is low a held result stays on rsp unchanged, the
//   request register keeps one more transaction, and req.ready drops only
//   when both registers are full.
// ============================================================================
module z80_alu_with_flags_core (
    input  logic                 clk,
    input  logic                 rst_n,
    z80alu_req_if.sink           req,
    z80alu_rsp_if.source         rsp
);
    import z80alu_pkg::*;

    // Stage 1: captured request
    logic     req_valid_reg;
    logic     req_valid_next;
    alu_req_t req_data_reg;

    // Stage 2: registered result
    logic     rsp_valid_reg;
    logic     rsp_valid_next;
    alu_rsp_t rsp_data_reg;

    alu_req_t req_in;
    alu_rsp_t alu_out;
    logic     req_fire;
    logic     stage_advance;

    // Advance the result stage when it is empty or being drained
    assign stage_advance = !rsp_valid_reg || rsp.ready;
    assign req.ready     = !req_valid_reg || stage_advance;
    assign req_fire      = req.valid && req.ready;

    assign req_in.req_type  = req.req_type;
    assign req_in.operand_a = req.operand_a;
    assign req_in.operand_b = req.operand_b;
    assign req_in.flags_in  = req.flags_in;
    assign req_in.bit_index = req.bit_index;

    z80alu_calc u_calc (
        .req (req_data_reg),
        .rsp (alu_out)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (stage_advance)
        begin
            rsp_valid_next = req_valid_reg;
        end
        if (req.ready)
        begin
            req_valid_next = req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_data_reg <= req_in;
        end
        if (stage_advance && req_valid_reg)
        begin
            rsp_data_reg <= alu_out;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.result     = rsp_data_reg.result;
    assign rsp.flags_out  = rsp_data_reg.flags_out;
    assign rsp.write_back = rsp_data_reg.write_back;

endmodule
